// ===== rtl/dsgf_pkg.sv =====
// Shared types, codes and arithmetic helpers of the direct-sum gravity force core.
package dsgf_pkg;

    // Default size of the particle store.
    localparam int MAX_PARTICLES_DEF = 1024;

    // Field widths that the interface fixes.
    localparam int PCOUNT_W  = 11;
    localparam int INDEX_W   = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;

    // Inverse square root: 48 result bits, partial products kept in 98 bits.
    localparam int ROOT_BITS = 48;
    localparam int PQ_W      = 98;
    localparam int INV_W     = ROOT_BITS + 1;

    // Operation codes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SOFTENING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT     = 2'd2;

    // Saturation limits of a 48 bit signed force.
    localparam logic [63:0] F48_MAX_MAG = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] F48_MIN_MAG = 64'h0000_8000_0000_0000;
    localparam logic signed [49:0] F48_MAX = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [49:0] F48_MIN = -50'sh0_8000_0000_0000;

    // One request.
    typedef struct packed {
        logic                      operation;
        logic [INDEX_W-1:0]        particle_index;
        logic signed [31:0]        position_x;
        logic signed [31:0]        position_y;
        logic signed [31:0]        position_z;
        logic [31:0]               particle_mass;
    } t_req;

    // One result.
    typedef struct packed {
        logic [INDEX_W-1:0]        result_index;
        logic signed [47:0]        force_x;
        logic signed [47:0]        force_y;
        logic signed [47:0]        force_z;
        logic [1:0]                status;
    } t_rsp;

    // Data that travels down the inverse square root chain.
    typedef struct packed {
        logic                      valid;
        logic                      last;
        logic [63:0]               d2;
        logic [PQ_W-1:0]           p;
        logic [PQ_W-1:0]           q;
        logic [ROOT_BITS-1:0]      root;
        logic [31:0]               mass;
        logic signed [32:0]        dx;
        logic signed [32:0]        dy;
        logic signed [32:0]        dz;
    } t_cell;

    // Side data of the weight multipliers that still need the inverse distance.
    typedef struct packed {
        logic                      valid;
        logic                      last;
        logic [INV_W-1:0]          inv;
        logic signed [32:0]        dx;
        logic signed [32:0]        dy;
        logic signed [32:0]        dz;
    } t_pair_side;

    // Pair flags with the three deltas.
    typedef struct packed {
        logic                      valid;
        logic                      last;
        logic signed [32:0]        dx;
        logic signed [32:0]        dy;
        logic signed [32:0]        dz;
    } t_delta_side;

    // Magnitude of a 33 bit signed delta; it always fits in 32 bits.
    function automatic logic [31:0] abs33(logic signed [32:0] v);
        logic [32:0] n;
        n = v[32] ? (~v + 33'd1) : v;
        return n[31:0];
    endfunction

    // Unsigned 64 bit add that sticks at all ones.
    function automatic logic [63:0] sat_add64(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    // Signed force term from a rounded magnitude and the sign of its delta.
    function automatic logic signed [48:0] clamp_term(logic [63:0] mag, logic neg);
        logic [63:0] lim;
        logic [48:0] m;
        if (neg) begin
            lim = (mag > F48_MIN_MAG) ? F48_MIN_MAG : mag;
            m   = lim[48:0];
            return -$signed(m);
        end else begin
            lim = (mag > F48_MAX_MAG) ? F48_MAX_MAG : mag;
            m   = lim[48:0];
            return $signed(m);
        end
    endfunction

    // 48 bit signed accumulate with saturation.
    function automatic logic signed [47:0] sat_acc48(logic signed [47:0] acc,
                                                     logic signed [48:0] term);
        logic signed [49:0] s;
        s = {{2{acc[47]}}, acc} + {term[48], term};
        if (s > F48_MAX) begin
            return F48_MAX[47:0];
        end else if (s < F48_MIN) begin
            return F48_MIN[47:0];
        end
        return s[47:0];
    endfunction

endpackage

// ===== rtl/dsgf_ram.sv =====
// Generic simple dual-port RAM with registered read.
module dsgf_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dsgf_isqrt_cell.sv =====
// One cell of the inverse square root chain: decides one bit of the root.
module dsgf_isqrt_cell import dsgf_pkg::*; #(
    parameter int BIT_POS = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cell i_cell,
    output t_cell o_cell
);

    // The candidate t = 2m+1 grows by a = 2^(BIT_POS+1) when this bit is set.
    // With P = t^2*d2 and Q = t*d2: P' = P + 2aQ + a^2*d2, Q' = Q + a*d2.
    logic [PQ_W+48:0]  w_q_sh;
    logic [159:0]      w_d_sh;
    logic [PQ_W+1:0]   w_sum;
    logic [PQ_W-1:0]   w_q_add;
    logic              w_take;
    t_cell             r_cell;

    assign w_q_sh  = {49'b0, i_cell.q} << (BIT_POS + 2);
    assign w_d_sh  = {96'b0, i_cell.d2} << (2 * BIT_POS + 2);
    assign w_sum   = {2'b0, i_cell.p} + {2'b0, w_q_sh[PQ_W-1:0]} + {2'b0, w_d_sh[PQ_W-1:0]};
    assign w_q_add = {34'b0, i_cell.d2} << (BIT_POS + 1);

    // The bit is kept while the new P stays below 2^98.
    assign w_take = ~(|w_q_sh[PQ_W+48:PQ_W]) & ~(|w_d_sh[159:PQ_W])
                  & (w_sum[PQ_W+1:PQ_W] == 2'b00);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= '0;
        end else begin
            r_cell <= i_cell;
            if (w_take) begin
                r_cell.p             <= w_sum[PQ_W-1:0];
                r_cell.q             <= i_cell.q + w_q_add;
                r_cell.root[BIT_POS] <= 1'b1;
            end
        end
    end

    assign o_cell = r_cell;

endmodule

// ===== rtl/dsgf_mul.sv =====
// Pipelined 64 by 64 multiplier with round-half-up shift and saturation to 64 bits.
module dsgf_mul #(
    parameter int SHIFT  = 32,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [63:0]       i_a,
    input  logic [63:0]       i_b,
    input  logic [SIDE_W-1:0] i_side,
    output logic [63:0]       o_res,
    output logic [SIDE_W-1:0] o_side
);

    logic [63:0]       r_pp00, r_pp01, r_pp10, r_pp11;
    logic [127:0]      r_prod;
    logic [63:0]       r_res;
    logic [SIDE_W-1:0] r_side1, r_side2, r_side3;
    logic [128:0]      w_rnd;
    logic [128:0]      w_hi;

    // Stage one: four 32 by 32 partial products.
    always_ff @(posedge i_clk) begin
        r_pp00 <= {32'b0, i_a[31:0]}  * {32'b0, i_b[31:0]};
        r_pp01 <= {32'b0, i_a[31:0]}  * {32'b0, i_b[63:32]};
        r_pp10 <= {32'b0, i_a[63:32]} * {32'b0, i_b[31:0]};
        r_pp11 <= {32'b0, i_a[63:32]} * {32'b0, i_b[63:32]};
    end

    // Stage two: full product.
    always_ff @(posedge i_clk) begin
        r_prod <= {64'b0, r_pp00} + {32'b0, r_pp01, 32'b0} + {32'b0, r_pp10, 32'b0}
                + {r_pp11, 64'b0};
    end

    // Stage three: round half up, shift, saturate.
    assign w_rnd = {1'b0, r_prod} + (129'd1 << (SHIFT - 1));
    assign w_hi  = w_rnd >> SHIFT;

    always_ff @(posedge i_clk) begin
        r_res <= (|w_hi[128:64]) ? '1 : w_hi[63:0];
    end

    // Side data follows the product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side1 <= '0;
            r_side2 <= '0;
            r_side3 <= '0;
        end else begin
            r_side1 <= i_side;
            r_side2 <= r_side1;
            r_side3 <= r_side2;
        end
    end

    assign o_res  = r_res;
    assign o_side = r_side3;

endmodule

// ===== rtl/direct_sum_gravity_force_core.sv =====
// Direct-sum softened gravity force core: particle store and force pipeline.
//
// A load request writes one particle into the store and gives no result.
// A query for index i streams every stored particle below the effective count out of the
// store, one pair a cycle, through a fixed pipeline: deltas, squares, softened distance,
// a chain of 48 cells that each settle one bit of the inverse distance, three weight
// multipliers and the force multipliers, and the saturating accumulators. The store read
// port sets the pace of one pair a cycle and the cell chain most of the latency.
// A query on an empty set or an index out of range answers in the next cycle. busy is
// high while a query is in flight; each result is shown for one cycle with o_result_valid
// and cannot be held off.
module direct_sum_gravity_force_core import dsgf_pkg::*; #(
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_req                 i_request,
    output logic                 o_result_valid,
    output t_rsp                 o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(MAX_PARTICLES);
    localparam int CW = ($clog2(MAX_PARTICLES + 1) > PCOUNT_W) ?
                        $clog2(MAX_PARTICLES + 1) : PCOUNT_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_PARTICLES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_OWN,
        S_STREAM,
        S_DRAIN
    } t_state;

    // Configuration registers.
    logic [31:0]         r_softening;
    logic [63:0]         r_min_d2;
    logic [PCOUNT_W-1:0] r_count_cfg;
    logic [63:0]         r_soft2;

    // Control.
    t_state              r_state;
    logic [CW-1:0]       r_j;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       r_count;
    logic signed [31:0]  r_own_x, r_own_y, r_own_z;
    logic                r_t1_valid, r_t1_last, r_t1_self;
    logic                r_out_valid;
    t_rsp                r_rsp;

    logic                w_accept;
    logic                w_query;
    logic [CW-1:0]       w_idx_ext;
    logic [CW-1:0]       w_cnt_ext;
    logic [CW-1:0]       w_count_eff;
    logic                w_we;
    logic [AW-1:0]       w_raddr;
    logic                w_issue_last;
    logic [31:0]         w_rd_x, w_rd_y, w_rd_z, w_rd_m;

    // Pipeline registers.
    t_delta_side         r_s2;
    logic [31:0]         r_s2_mass;
    t_delta_side         r_s3;
    logic [31:0]         r_s3_mass;
    logic [63:0]         r_sq_x, r_sq_y, r_sq_z;
    t_delta_side         r_s4;
    logic [31:0]         r_s4_mass;
    logic [63:0]         r_sum_xy, r_sum_zs;
    t_cell               r_s5;
    t_cell               w_chain [ROOT_BITS+1];
    logic [63:0]         w_d2;

    t_pair_side          w_side1_in, w_side1, w_side2;
    t_delta_side         w_side3_in, w_side3;
    logic [INV_W-1:0]    w_inv;
    logic [63:0]         w_res1, w_res2, w_res3;
    logic [63:0]         w_fx, w_fy, w_fz;
    logic [2:0]          w_fside_x;
    logic                w_fside_y, w_fside_z;

    logic                r_c_valid, r_c_last;
    logic signed [48:0]  r_term_x, r_term_y, r_term_z;
    logic signed [47:0]  r_acc_x, r_acc_y, r_acc_z;
    logic                r_acc_last;

    // Request handshake and index arithmetic.
    assign busy        = (r_state != S_IDLE);
    assign w_accept    = start && !busy;
    assign w_query     = w_accept && (i_request.operation == OP_QUERY);
    assign w_idx_ext   = CW'(i_request.particle_index);
    assign w_cnt_ext   = CW'(r_count_cfg);
    assign w_count_eff = (w_cnt_ext > MAX_C) ? MAX_C : w_cnt_ext;
    assign w_we        = w_accept && (i_request.operation == OP_LOAD) && (w_idx_ext < MAX_C);
    assign w_raddr     = (r_state == S_IDLE) ? w_idx_ext[AW-1:0] : r_j[AW-1:0];
    assign w_issue_last = (r_j == (r_count - CW'(1)));

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_softening <= '0;
            r_min_d2    <= '0;
            r_count_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SOFTENING: r_softening <= i_cfg_data[31:0];
                REG_MIN_DIST2: r_min_d2    <= i_cfg_data;
                REG_COUNT:     r_count_cfg <= i_cfg_data[PCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Squared softening length, recomputed from the stable register.
    always_ff @(posedge i_clk) begin
        r_soft2 <= r_softening * r_softening;
    end

    // Particle store.
    dsgf_ram #(.W(32), .DEPTH(MAX_PARTICLES)) u_ram_x (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_idx_ext[AW-1:0]),
        .i_wdata(i_request.position_x), .i_raddr(w_raddr), .o_rdata(w_rd_x)
    );
    dsgf_ram #(.W(32), .DEPTH(MAX_PARTICLES)) u_ram_y (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_idx_ext[AW-1:0]),
        .i_wdata(i_request.position_y), .i_raddr(w_raddr), .o_rdata(w_rd_y)
    );
    dsgf_ram #(.W(32), .DEPTH(MAX_PARTICLES)) u_ram_z (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_idx_ext[AW-1:0]),
        .i_wdata(i_request.position_z), .i_raddr(w_raddr), .o_rdata(w_rd_z)
    );
    dsgf_ram #(.W(32), .DEPTH(MAX_PARTICLES)) u_ram_m (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_idx_ext[AW-1:0]),
        .i_wdata(i_request.particle_mass), .i_raddr(w_raddr), .o_rdata(w_rd_m)
    );

    // Query sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_j         <= '0;
            r_idx       <= '0;
            r_count     <= '0;
            r_t1_valid  <= 1'b0;
            r_t1_last   <= 1'b0;
            r_t1_self   <= 1'b0;
            r_out_valid <= 1'b0;
            r_rsp       <= '0;
            r_own_x     <= '0;
            r_own_y     <= '0;
            r_own_z     <= '0;
        end else begin
            r_out_valid <= 1'b0;
            r_t1_valid  <= 1'b0;
            r_t1_last   <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_query) begin
                        r_idx   <= w_idx_ext;
                        r_count <= w_count_eff;
                        r_j     <= '0;
                        r_rsp.result_index <= i_request.particle_index;
                        r_rsp.force_x      <= '0;
                        r_rsp.force_y      <= '0;
                        r_rsp.force_z      <= '0;
                        if (w_count_eff == '0) begin
                            r_rsp.status <= STAT_EMPTY;
                            r_out_valid  <= 1'b1;
                        end else if (w_idx_ext >= w_count_eff) begin
                            r_rsp.status <= STAT_RANGE;
                            r_out_valid  <= 1'b1;
                        end else begin
                            r_state <= S_OWN;
                        end
                    end
                end
                S_OWN, S_STREAM: begin
                    // The first cycle sees the queried particle's own position.
                    if (r_state == S_OWN) begin
                        r_own_x <= w_rd_x;
                        r_own_y <= w_rd_y;
                        r_own_z <= w_rd_z;
                    end
                    r_t1_valid <= 1'b1;
                    r_t1_last  <= w_issue_last;
                    r_t1_self  <= (r_j == r_idx);
                    r_j        <= r_j + CW'(1);
                    r_state    <= w_issue_last ? S_DRAIN : S_STREAM;
                end
                S_DRAIN: begin
                    if (r_acc_last) begin
                        r_rsp.force_x <= r_acc_x;
                        r_rsp.force_y <= r_acc_y;
                        r_rsp.force_z <= r_acc_z;
                        r_rsp.status  <= STAT_OK;
                        r_out_valid   <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Deltas, squares and the softened distance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
            r_s3 <= '0;
            r_s4 <= '0;
            r_s5 <= '0;
        end else begin
            r_s2.valid <= r_t1_valid && !r_t1_self;
            r_s2.last  <= r_t1_valid && r_t1_last;
            r_s2.dx    <= {w_rd_x[31], w_rd_x} - {r_own_x[31], r_own_x};
            r_s2.dy    <= {w_rd_y[31], w_rd_y} - {r_own_y[31], r_own_y};
            r_s2.dz    <= {w_rd_z[31], w_rd_z} - {r_own_z[31], r_own_z};

            r_s3 <= r_s2;
            r_s4 <= r_s3;

            r_s5.valid <= r_s4.valid && (w_d2 > r_min_d2);
            r_s5.last  <= r_s4.last;
            r_s5.d2    <= w_d2;
            r_s5.p     <= PQ_W'(w_d2);
            r_s5.q     <= PQ_W'(w_d2);
            r_s5.root  <= '0;
            r_s5.mass  <= r_s4_mass;
            r_s5.dx    <= r_s4.dx;
            r_s5.dy    <= r_s4.dy;
            r_s5.dz    <= r_s4.dz;
        end
    end

    assign w_d2 = sat_add64(r_sum_xy, r_sum_zs);

    always_ff @(posedge i_clk) begin
        r_s2_mass <= w_rd_m;
        r_s3_mass <= r_s2_mass;
        r_s4_mass <= r_s3_mass;
        r_sq_x    <= abs33(r_s2.dx) * abs33(r_s2.dx);
        r_sq_y    <= abs33(r_s2.dy) * abs33(r_s2.dy);
        r_sq_z    <= abs33(r_s2.dz) * abs33(r_s2.dz);
        r_sum_xy  <= sat_add64(r_sq_x, r_sq_y);
        r_sum_zs  <= sat_add64(r_sq_z, r_soft2);
    end

    // Inverse distance: one cell per root bit, most significant first.
    assign w_chain[0] = r_s5;

    for (genvar g = 0; g < ROOT_BITS; g++) begin : g_cell
        dsgf_isqrt_cell #(.BIT_POS(ROOT_BITS - 1 - g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_cell (w_chain[g]),
            .o_cell (w_chain[g+1])
        );
    end

    assign w_inv = {1'b0, w_chain[ROOT_BITS].root} + INV_W'(1);

    // Weights: mass / d^3 as three rounded multiplications by 1/d.
    assign w_side1_in.valid = w_chain[ROOT_BITS].valid;
    assign w_side1_in.last  = w_chain[ROOT_BITS].last;
    assign w_side1_in.inv   = w_inv;
    assign w_side1_in.dx    = w_chain[ROOT_BITS].dx;
    assign w_side1_in.dy    = w_chain[ROOT_BITS].dy;
    assign w_side1_in.dz    = w_chain[ROOT_BITS].dz;

    dsgf_mul #(.SHIFT(16), .SIDE_W($bits(t_pair_side))) u_mul_w1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_a({32'b0, w_chain[ROOT_BITS].mass}), .i_b({15'b0, w_inv}),
        .i_side(w_side1_in), .o_res(w_res1), .o_side(w_side1)
    );

    dsgf_mul #(.SHIFT(32), .SIDE_W($bits(t_pair_side))) u_mul_w2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_a(w_res1), .i_b({15'b0, w_side1.inv}),
        .i_side(w_side1), .o_res(w_res2), .o_side(w_side2)
    );

    assign w_side3_in.valid = w_side2.valid;
    assign w_side3_in.last  = w_side2.last;
    assign w_side3_in.dx    = w_side2.dx;
    assign w_side3_in.dy    = w_side2.dy;
    assign w_side3_in.dz    = w_side2.dz;

    dsgf_mul #(.SHIFT(32), .SIDE_W($bits(t_delta_side))) u_mul_w3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_a(w_res2), .i_b({15'b0, w_side2.inv}),
        .i_side(w_side3_in), .o_res(w_res3), .o_side(w_side3)
    );

    // Force magnitudes per axis.
    dsgf_mul #(.SHIFT(24), .SIDE_W(3)) u_mul_fx (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_a({32'b0, abs33(w_side3.dx)}), .i_b(w_res3),
        .i_side({w_side3.valid, w_side3.last, w_side3.dx[32]}),
        .o_res(w_fx), .o_side(w_fside_x)
    );

    dsgf_mul #(.SHIFT(24), .SIDE_W(1)) u_mul_fy (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_a({32'b0, abs33(w_side3.dy)}), .i_b(w_res3),
        .i_side(w_side3.dy[32]), .o_res(w_fy), .o_side(w_fside_y)
    );

    dsgf_mul #(.SHIFT(24), .SIDE_W(1)) u_mul_fz (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_a({32'b0, abs33(w_side3.dz)}), .i_b(w_res3),
        .i_side(w_side3.dz[32]), .o_res(w_fz), .o_side(w_fside_z)
    );

    // Signed, clamped terms.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_c_last  <= 1'b0;
        end else begin
            r_c_valid <= w_fside_x[2];
            r_c_last  <= w_fside_x[1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_term_x <= clamp_term(w_fx, w_fside_x[0]);
        r_term_y <= clamp_term(w_fy, w_fside_y);
        r_term_z <= clamp_term(w_fz, w_fside_z);
    end

    // Saturating accumulators, cleared when a query is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_x    <= '0;
            r_acc_y    <= '0;
            r_acc_z    <= '0;
            r_acc_last <= 1'b0;
        end else begin
            r_acc_last <= r_c_last;
            if (w_query) begin
                r_acc_x <= '0;
                r_acc_y <= '0;
                r_acc_z <= '0;
            end else if (r_c_valid) begin
                r_acc_x <= sat_acc48(r_acc_x, r_term_x);
                r_acc_y <= sat_acc48(r_acc_y, r_term_y);
                r_acc_z <= sat_acc48(r_acc_z, r_term_z);
            end
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_rsp;

endmodule
